@@ rtl/core/ffra_pkg.sv @@
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit record allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int DEF_HOLE_DEPTH   = 16;
    localparam int DEF_RECORD_DEPTH = 64;
    localparam int DEF_OFFSET_BITS  = 24;

    localparam int OP_W     = 2;
    localparam int SIZE_W   = 16;
    localparam int IDX_W    = 6;
    localparam int STS_W    = 2;
    localparam int OFS_OUT_W = 24;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_DELETED = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
    localparam logic [STS_W-1:0] STS_UNUSED  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_PLACE,
        S_SHIFT,
        S_APPEND,
        S_ENT_WAIT,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SRCH_INIT,
        CMD_SRCH,
        CMD_PLACE,
        CMD_SHIFT,
        CMD_APPEND,
        CMD_ENT_RD,
        CMD_ENT_DONE,
        CMD_RES_FULL,
        CMD_RES_UNUSED,
        CMD_RES_ZERO,
        CMD_PUSH
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            tab_full;
        logic            idx_unused;
        logic            srch_hit;
        logic            srch_miss;
        logic            left_zero;
        logic            shift_done;
        logic            out_free;
    } sts_t;

endpackage

@@ rtl/core/ffra_ram.sv @@
// ----------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/ffra_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: steps each item through decode, the hole search, hole update
// and table access that its op needs, and result hand-off.
// ----------------------------------------------------------------------------
module ffra_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ffra_pkg::sts_t sts,
    output ffra_pkg::cmd_t cmd
);

    ffra_pkg::state_t state_reg;
    ffra_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffra_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = ffra_pkg::CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ffra_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd        = ffra_pkg::CMD_LOAD;
                    state_next = ffra_pkg::S_DECODE;
                end
            end
            ffra_pkg::S_DECODE: begin
                unique case (sts.op) inside
                    ffra_pkg::OP_ADD: begin
                        if (sts.tab_full) begin
                            cmd        = ffra_pkg::CMD_RES_FULL;
                            state_next = ffra_pkg::S_FINISH;
                        end else begin
                            cmd        = ffra_pkg::CMD_SRCH_INIT;
                            state_next = ffra_pkg::S_SEARCH;
                        end
                    end
                    ffra_pkg::OP_REMOVE, ffra_pkg::OP_READ: begin
                        if (sts.idx_unused) begin
                            cmd        = ffra_pkg::CMD_RES_UNUSED;
                            state_next = ffra_pkg::S_FINISH;
                        end else begin
                            cmd        = ffra_pkg::CMD_ENT_RD;
                            state_next = ffra_pkg::S_ENT_WAIT;
                        end
                    end
                    default: begin
                        cmd        = ffra_pkg::CMD_RES_ZERO;
                        state_next = ffra_pkg::S_FINISH;
                    end
                endcase
            end
            ffra_pkg::S_SEARCH: begin
                cmd = ffra_pkg::CMD_SRCH;
                if (sts.srch_hit) begin
                    state_next = ffra_pkg::S_PLACE;
                end else if (sts.srch_miss) begin
                    state_next = ffra_pkg::S_APPEND;
                end
            end
            ffra_pkg::S_PLACE: begin
                cmd        = ffra_pkg::CMD_PLACE;
                state_next = sts.left_zero ? ffra_pkg::S_SHIFT : ffra_pkg::S_APPEND;
            end
            ffra_pkg::S_SHIFT: begin
                cmd = ffra_pkg::CMD_SHIFT;
                if (sts.shift_done) begin
                    state_next = ffra_pkg::S_APPEND;
                end
            end
            ffra_pkg::S_APPEND: begin
                cmd        = ffra_pkg::CMD_APPEND;
                state_next = ffra_pkg::S_FINISH;
            end
            ffra_pkg::S_ENT_WAIT: begin
                cmd        = ffra_pkg::CMD_ENT_DONE;
                state_next = ffra_pkg::S_FINISH;
            end
            ffra_pkg::S_FINISH: begin
                if (sts.out_free) begin
                    cmd        = ffra_pkg::CMD_PUSH;
                    state_next = ffra_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ffra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/ffra_dp.sv @@
// ----------------------------------------------------------------------------
// ffra_dp
// Datapath: hole list and record table memories, counters, end pointer,
// first-fit compare, result staging and output register.
// ----------------------------------------------------------------------------
module ffra_dp #(
    parameter int HOLE_DEPTH   = ffra_pkg::DEF_HOLE_DEPTH,
    parameter int RECORD_DEPTH = ffra_pkg::DEF_RECORD_DEPTH,
    parameter int OFFSET_BITS  = ffra_pkg::DEF_OFFSET_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ffra_pkg::cmd_t                  cmd,
    output ffra_pkg::sts_t                  sts,
    input  logic [ffra_pkg::OP_W-1:0]       in_op,
    input  logic [ffra_pkg::SIZE_W-1:0]     in_rec_size,
    input  logic [ffra_pkg::IDX_W-1:0]      in_rec_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ffra_pkg::STS_W-1:0]      out_status,
    output logic [ffra_pkg::OFS_OUT_W-1:0]  out_rec_offset,
    output logic [ffra_pkg::SIZE_W-1:0]     out_size,
    output logic                            out_reused_hole,
    output logic [ffra_pkg::IDX_W-1:0]      out_new_index
);

    localparam int HA = $clog2(HOLE_DEPTH);
    localparam int HC = $clog2(HOLE_DEPTH + 1);
    localparam int EA = $clog2(RECORD_DEPTH);
    localparam int EC = $clog2(RECORD_DEPTH + 1);
    localparam int CW = (EC > ffra_pkg::IDX_W) ? EC : ffra_pkg::IDX_W;
    localparam int OB = OFFSET_BITS;
    localparam int SW = ffra_pkg::SIZE_W;
    localparam int HW = OB + SW;
    localparam int EW = OB + SW + 1;

    // control state
    logic [HC-1:0] hole_count_reg, hole_count_next;
    logic [EC-1:0] entry_count_reg, entry_count_next;
    logic [OB-1:0] end_ptr_reg, end_ptr_next;
    logic          pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;

    // payload
    logic [ffra_pkg::OP_W-1:0]      op_reg, op_next;
    logic [SW-1:0]                  size_reg, size_next;
    logic [ffra_pkg::IDX_W-1:0]     index_reg, index_next;
    logic [HC-1:0]                  ptr_reg, ptr_next;
    logic [HA-1:0]                  found_idx_reg, found_idx_next;
    logic [OB-1:0]                  found_off_reg, found_off_next;
    logic [SW-1:0]                  found_size_reg, found_size_next;
    logic                           reused_reg, reused_next;
    logic [ffra_pkg::STS_W-1:0]     stg_status_reg, stg_status_next;
    logic [ffra_pkg::OFS_OUT_W-1:0] stg_off_reg, stg_off_next;
    logic [SW-1:0]                  stg_size_reg, stg_size_next;
    logic                           stg_reused_reg, stg_reused_next;
    logic [ffra_pkg::IDX_W-1:0]     stg_idx_reg, stg_idx_next;
    logic [ffra_pkg::STS_W-1:0]     res_status_reg, res_status_next;
    logic [ffra_pkg::OFS_OUT_W-1:0] res_off_reg, res_off_next;
    logic [SW-1:0]                  res_size_reg, res_size_next;
    logic                           res_reused_reg, res_reused_next;
    logic [ffra_pkg::IDX_W-1:0]     res_idx_reg, res_idx_next;

    // memories
    logic          h_we, h_re;
    logic [HA-1:0] h_waddr, h_raddr;
    logic [HW-1:0] h_wdata, h_rdata;
    logic          e_we, e_re;
    logic [EA-1:0] e_waddr, e_raddr;
    logic [EW-1:0] e_wdata, e_rdata;

    logic [OB-1:0] rd_off, e_off, app_off;
    logic [SW-1:0] rd_size, e_size, left;
    logic          e_vld;
    logic          ptr_end, srch_hit, srch_miss, shift_done;
    logic          holes_full, tab_full, idx_unused, out_free;

    ffra_ram #(.WIDTH(HW), .DEPTH(HOLE_DEPTH)) u_hole_ram (
        .aclk    (aclk),
        .wr_en   (h_we),
        .wr_addr (h_waddr),
        .wr_data (h_wdata),
        .rd_en   (h_re),
        .rd_addr (h_raddr),
        .rd_data (h_rdata)
    );

    ffra_ram #(.WIDTH(EW), .DEPTH(RECORD_DEPTH)) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (e_we),
        .wr_addr (e_waddr),
        .wr_data (e_wdata),
        .rd_en   (e_re),
        .rd_addr (e_raddr),
        .rd_data (e_rdata)
    );

    assign rd_off  = h_rdata[OB-1:0];
    assign rd_size = h_rdata[HW-1:OB];
    assign e_off   = e_rdata[OB-1:0];
    assign e_size  = e_rdata[OB+SW-1:OB];
    assign e_vld   = e_rdata[EW-1];
    assign left    = found_size_reg - size_reg;
    assign app_off = reused_reg ? found_off_reg : end_ptr_reg;

    assign ptr_end    = (ptr_reg >= hole_count_reg);
    assign srch_hit   = pend_reg && (rd_size >= size_reg);
    assign srch_miss  = !srch_hit && ptr_end;
    assign shift_done = ptr_end && !pend_reg;
    assign holes_full = (hole_count_reg == HC'(HOLE_DEPTH));
    assign tab_full   = (entry_count_reg == EC'(RECORD_DEPTH));
    assign idx_unused = (CW'(index_reg) >= CW'(entry_count_reg));
    assign out_free   = !out_valid_reg || out_ready;

    assign sts.op         = op_reg;
    assign sts.tab_full   = tab_full;
    assign sts.idx_unused = idx_unused;
    assign sts.srch_hit   = srch_hit;
    assign sts.srch_miss  = srch_miss;
    assign sts.left_zero  = (left == '0);
    assign sts.shift_done = shift_done;
    assign sts.out_free   = out_free;

    always_comb begin
        hole_count_next  = hole_count_reg;
        entry_count_next = entry_count_reg;
        end_ptr_next     = end_ptr_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg;
        op_next          = op_reg;
        size_next        = size_reg;
        index_next       = index_reg;
        ptr_next         = ptr_reg;
        found_idx_next   = found_idx_reg;
        found_off_next   = found_off_reg;
        found_size_next  = found_size_reg;
        reused_next      = reused_reg;
        stg_status_next  = stg_status_reg;
        stg_off_next     = stg_off_reg;
        stg_size_next    = stg_size_reg;
        stg_reused_next  = stg_reused_reg;
        stg_idx_next     = stg_idx_reg;
        res_status_next  = res_status_reg;
        res_off_next     = res_off_reg;
        res_size_next    = res_size_reg;
        res_reused_next  = res_reused_reg;
        res_idx_next     = res_idx_reg;
        h_we    = 1'b0;
        h_waddr = '0;
        h_wdata = '0;
        h_re    = 1'b0;
        h_raddr = '0;
        e_we    = 1'b0;
        e_waddr = '0;
        e_wdata = '0;
        e_re    = 1'b0;
        e_raddr = '0;

        if (out_ready) begin
            out_valid_next = 1'b0;
        end

        case (cmd)
            ffra_pkg::CMD_LOAD: begin
                op_next    = in_op;
                size_next  = in_rec_size;
                index_next = in_rec_index;
            end
            ffra_pkg::CMD_SRCH_INIT: begin
                ptr_next    = '0;
                pend_next   = 1'b0;
                reused_next = 1'b0;
            end
            ffra_pkg::CMD_SRCH: begin
                if (srch_hit) begin
                    found_idx_next  = HA'(ptr_reg - HC'(1));
                    found_off_next  = rd_off;
                    found_size_next = rd_size;
                    reused_next     = 1'b1;
                    pend_next       = 1'b0;
                end else if (!ptr_end) begin
                    h_re      = 1'b1;
                    h_raddr   = HA'(ptr_reg);
                    ptr_next  = ptr_reg + HC'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
            end
            ffra_pkg::CMD_PLACE: begin
                if (left != '0) begin
                    h_we    = 1'b1;
                    h_waddr = found_idx_reg;
                    h_wdata = {left, found_off_reg + OB'(size_reg)};
                end else begin
                    ptr_next  = HC'(found_idx_reg) + HC'(1);
                    pend_next = 1'b0;
                end
            end
            ffra_pkg::CMD_SHIFT: begin
                // data read last cycle moves down one place
                if (pend_reg) begin
                    h_we    = 1'b1;
                    h_waddr = HA'(ptr_reg - HC'(2));
                    h_wdata = h_rdata;
                end
                if (!ptr_end) begin
                    h_re      = 1'b1;
                    h_raddr   = HA'(ptr_reg);
                    ptr_next  = ptr_reg + HC'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (shift_done) begin
                    hole_count_next = hole_count_reg - HC'(1);
                end
            end
            ffra_pkg::CMD_APPEND: begin
                if (!reused_reg) begin
                    end_ptr_next = end_ptr_reg + OB'(size_reg);
                end
                e_we             = 1'b1;
                e_waddr          = EA'(entry_count_reg);
                e_wdata          = {1'b1, size_reg, app_off};
                entry_count_next = entry_count_reg + EC'(1);
                stg_status_next  = ffra_pkg::STS_OK;
                stg_off_next     = ffra_pkg::OFS_OUT_W'(app_off);
                stg_size_next    = size_reg;
                stg_reused_next  = reused_reg;
                stg_idx_next     = ffra_pkg::IDX_W'(entry_count_reg);
            end
            ffra_pkg::CMD_ENT_RD: begin
                e_re    = 1'b1;
                e_raddr = EA'(index_reg);
            end
            ffra_pkg::CMD_ENT_DONE: begin
                stg_off_next    = '0;
                stg_size_next   = '0;
                stg_reused_next = 1'b0;
                stg_idx_next    = '0;
                if (!e_vld) begin
                    stg_status_next = ffra_pkg::STS_DELETED;
                end else if (op_reg == ffra_pkg::OP_REMOVE && holes_full) begin
                    stg_status_next = ffra_pkg::STS_FULL;
                end else begin
                    stg_status_next = ffra_pkg::STS_OK;
                    stg_off_next    = ffra_pkg::OFS_OUT_W'(e_off);
                    stg_size_next   = e_size;
                    if (op_reg == ffra_pkg::OP_REMOVE) begin
                        e_we            = 1'b1;
                        e_waddr         = EA'(index_reg);
                        e_wdata         = {1'b0, e_size, e_off};
                        h_we            = 1'b1;
                        h_waddr         = HA'(hole_count_reg);
                        h_wdata         = {e_size, e_off};
                        hole_count_next = hole_count_reg + HC'(1);
                    end
                end
            end
            ffra_pkg::CMD_RES_FULL: begin
                stg_status_next = ffra_pkg::STS_FULL;
                stg_off_next    = '0;
                stg_size_next   = '0;
                stg_reused_next = 1'b0;
                stg_idx_next    = '0;
            end
            ffra_pkg::CMD_RES_UNUSED: begin
                stg_status_next = ffra_pkg::STS_UNUSED;
                stg_off_next    = '0;
                stg_size_next   = '0;
                stg_reused_next = 1'b0;
                stg_idx_next    = '0;
            end
            ffra_pkg::CMD_RES_ZERO: begin
                stg_status_next = ffra_pkg::STS_OK;
                stg_off_next    = '0;
                stg_size_next   = '0;
                stg_reused_next = 1'b0;
                stg_idx_next    = '0;
            end
            ffra_pkg::CMD_PUSH: begin
                res_status_next = stg_status_reg;
                res_off_next    = stg_off_reg;
                res_size_next   = stg_size_reg;
                res_reused_next = stg_reused_reg;
                res_idx_next    = stg_idx_reg;
                out_valid_next  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hole_count_reg  <= '0;
            entry_count_reg <= '0;
            end_ptr_reg     <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            hole_count_reg  <= hole_count_next;
            entry_count_reg <= entry_count_next;
            end_ptr_reg     <= end_ptr_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        index_reg      <= index_next;
        ptr_reg        <= ptr_next;
        found_idx_reg  <= found_idx_next;
        found_off_reg  <= found_off_next;
        found_size_reg <= found_size_next;
        reused_reg     <= reused_next;
        stg_status_reg <= stg_status_next;
        stg_off_reg    <= stg_off_next;
        stg_size_reg   <= stg_size_next;
        stg_reused_reg <= stg_reused_next;
        stg_idx_reg    <= stg_idx_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_size_reg   <= res_size_next;
        res_reused_reg <= res_reused_next;
        res_idx_reg    <= res_idx_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = res_status_reg;
    assign out_rec_offset  = res_off_reg;
    assign out_size        = res_size_reg;
    assign out_reused_hole = res_reused_reg;
    assign out_new_index   = res_idx_reg;

    a_hole_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hole_count_reg <= HC'(HOLE_DEPTH))
        else $error("hole count above free list depth");

    a_entry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= EC'(RECORD_DEPTH))
        else $error("entry count above table depth");

    a_entry_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg >= $past(entry_count_reg))
        else $error("entry count went down");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == ffra_pkg::CMD_PUSH) |-> out_free)
        else $error("result pushed over an untaken item");

endmodule

@@ rtl/core/first_fit_record_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Full, unused-index and unknown ops go from decode straight to the result;
//   remove and read access the record table, and add walks the free list, may
//   shift holes and appends (walk and shift together visit each hole at most once).
// Throughput: one item at a time; the next item is accepted once its result
//   has been pushed into the output register, which holds it until taken.
// Reset: synchronous, aresetn low empties the free list and record table.
// ----------------------------------------------------------------------------
// first_fit_record_allocator_top
// First-fit allocator for variable-size records with an ordered free list.
// ----------------------------------------------------------------------------
module first_fit_record_allocator_top #(
    parameter int HOLE_DEPTH   = ffra_pkg::DEF_HOLE_DEPTH,
    parameter int RECORD_DEPTH = ffra_pkg::DEF_RECORD_DEPTH,
    parameter int OFFSET_BITS  = ffra_pkg::DEF_OFFSET_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // rec_size[15:0], rec_index[21:16], zero
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // rec_offset[23:0], size_out[39:24],
                                        // reused_hole[40], new_index[46:41], zero
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    ffra_pkg::cmd_t cmd;
    ffra_pkg::sts_t sts;

    logic [ffra_pkg::STS_W-1:0]     res_status;
    logic [ffra_pkg::OFS_OUT_W-1:0] res_offset;
    logic [ffra_pkg::SIZE_W-1:0]    res_size;
    logic                           res_reused;
    logic [ffra_pkg::IDX_W-1:0]     res_index;

    ffra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffra_dp #(
        .HOLE_DEPTH   (HOLE_DEPTH),
        .RECORD_DEPTH (RECORD_DEPTH),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_op           (s_axis_tuser),
        .in_rec_size     (s_axis_tdata[15:0]),
        .in_rec_index    (s_axis_tdata[21:16]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_status      (res_status),
        .out_rec_offset  (res_offset),
        .out_size        (res_size),
        .out_reused_hole (res_reused),
        .out_new_index   (res_index)
    );

    assign m_axis_tdata = {1'b0, res_index, res_reused, res_size, res_offset};
    assign m_axis_tuser = res_status;

endmodule
